/* design/frta_pkg.sv */
// shared constants for the free range table allocator
// no dependencies
package frta_pkg;
    localparam int MAP_ENTRIES = 32;
    localparam int IDX_W = 5;
    localparam int CNT_W = 6;
    localparam int PAGE_BITS = 12;
    localparam logic [31:0] ADDR_LIMIT = 32'hFFFFF000;
    localparam logic [31:0] WORD_MAX = 32'hffffffff;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_CUT = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;
    localparam logic [1:0] OP_PAGE = 2'd3;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_SLOT = 2'd1;
    localparam logic [1:0] ST_NO_FIT = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;
endpackage

/* design/free_range_table_allocator_top.sv */
// Free range table allocator: a table of 32 free address ranges kept in two
// synchronous memories, serviced by a sequencer that reads one slot at a time
// with a read, modify and write back. Placing a range scans for the first free
// slot. A cut scans every used slot and places the remainders of each entry
// that it overlaps, at most two per overlapping entry, so the work of a cut or
// an allocate lowest fit grows with the number of entries that overlap the cut.
// One transaction in, one transaction out; the next input is taken once the
// result is delivered.
// depends on frta_pkg
module free_range_table_allocator_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // addr, len, end_addr
    input  logic [1:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // result_addr, status, high_water, allocated_bytes, entries_used
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RD   = 5'd1;
    localparam logic [4:0] S_EV   = 5'd2;
    localparam logic [4:0] S_PUT  = 5'd3;
    localparam logic [4:0] S_PRD  = 5'd4;
    localparam logic [4:0] S_PEV  = 5'd5;
    localparam logic [4:0] S_OUT  = 5'd6;
    localparam logic [4:0] S_CUT2 = 5'd7;

    localparam logic [1:0] K_ADD  = 2'd0;
    localparam logic [1:0] K_CUT  = 2'd1;
    localparam logic [1:0] K_FIND = 2'd2;
    localparam logic [1:0] K_PAGE = 2'd3;

    localparam logic [63:0] PG_MASK = (64'd1 << frta_pkg::PAGE_BITS) - 64'd1;
    localparam logic [31:0] PG_SIZE = 32'd1 << frta_pkg::PAGE_BITS;

    logic [31:0] mem_start [frta_pkg::MAP_ENTRIES];
    logic [31:0] mem_len [frta_pkg::MAP_ENTRIES];
    logic [31:0] rd_start, rd_len;
    logic [frta_pkg::IDX_W-1:0] rd_addr, wr_addr;
    logic        wr_en;
    logic [31:0] wr_start, wr_len;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_start[wr_addr] <= wr_start;
            mem_len[wr_addr] <= wr_len;
        end
        rd_start <= mem_start[rd_addr];
        rd_len <= mem_len[rd_addr];
    end

    // reset clears slots through per-slot valid bits
    logic [frta_pkg::MAP_ENTRIES-1:0] vld_reg;
    logic        rd_vld_reg;
    logic [31:0] e_start, e_len;
    assign e_start = rd_vld_reg ? rd_start : 32'd0;
    assign e_len = rd_vld_reg ? rd_len : 32'd0;

    logic [4:0]  state_reg;
    logic [1:0]  kind_reg;
    logic [frta_pkg::CNT_W-1:0] idx_reg;
    logic [63:0] addr_reg, len_reg;
    logic [32:0] cs_reg, ce_reg;
    logic [32:0] pa_reg, pl_reg;
    logic [32:0] rem_a_reg, rem_l_reg;
    logic        rem_pend_reg;
    logic [1:0]  status_reg;
    logic [31:0] result_reg;
    logic [5:0]  slot_cnt_reg;
    logic [31:0] top_reg, bytes_reg;
    logic        found_reg;
    logic [31:0] lowest_reg;
    logic [32:0] need_reg;
    logic        put_ret_cut_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = {slot_cnt_reg, bytes_reg, top_reg, status_reg, result_reg};
    assign rd_addr = idx_reg[frta_pkg::IDX_W-1:0];

    // add normalization
    logic [63:0] na_a, na_l, na_a2, na_l2;
    logic        na_drop;
    always_comb
    begin
        na_a = addr_reg;
        na_l = len_reg;
        na_drop = 1'b0;
        if (na_a > {32'd0, frta_pkg::ADDR_LIMIT})
            na_drop = 1'b1;
        if (na_l > {32'd0, frta_pkg::ADDR_LIMIT} - na_a)
            na_l = {32'd0, frta_pkg::ADDR_LIMIT} - na_a;
        if (na_l == 64'd0)
            na_drop = 1'b1;
        na_a2 = (na_a + PG_MASK) & ~PG_MASK;
        na_l2 = na_l & ~PG_MASK;
        if (na_a2 > {32'd0, frta_pkg::ADDR_LIMIT})
            na_drop = 1'b1;
        if (na_a2 + na_l2 > {32'd0, frta_pkg::ADDR_LIMIT})
            na_l2 = ({32'd0, frta_pkg::ADDR_LIMIT} - na_a2) & ~PG_MASK;
    end

    logic [32:0] ev_me, ev_ss, ev_se;
    always_comb
    begin
        ev_me = {1'b0, e_start} + {1'b0, e_len};
        ev_ss = (cs_reg > {1'b0, e_start}) ? cs_reg : {1'b0, e_start};
        ev_se = (ce_reg < ev_me) ? ce_reg : ev_me;
    end

    logic [5:0] scan_lim;
    assign scan_lim = (slot_cnt_reg > 6'(frta_pkg::MAP_ENTRIES)) ?
        6'(frta_pkg::MAP_ENTRIES) : slot_cnt_reg;

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = idx_reg[frta_pkg::IDX_W-1:0];
        wr_start = 32'd0;
        wr_len = 32'd0;
        if (state_reg == S_EV && kind_reg == K_CUT && idx_reg < scan_lim
            && ev_ss < ev_se)
            wr_en = 1'b1;
        if (state_reg == S_EV && kind_reg == K_PAGE && e_len >= PG_SIZE)
        begin
            wr_en = 1'b1;
            wr_start = e_start;
            wr_len = e_len - PG_SIZE;
        end
        if (state_reg == S_PEV && e_len == 32'd0)
        begin
            wr_en = 1'b1;
            wr_addr = idx_reg[frta_pkg::IDX_W-1:0];
            wr_start = pa_reg[31:0];
            wr_len = pl_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg <= '0;
            rd_vld_reg <= 1'b0;
            slot_cnt_reg <= '0;
            top_reg <= '0;
            bytes_reg <= '0;
            idx_reg <= '0;
            kind_reg <= K_ADD;
            status_reg <= frta_pkg::ST_OK;
            result_reg <= '0;
            rem_pend_reg <= 1'b0;
            found_reg <= 1'b0;
            put_ret_cut_reg <= 1'b0;
            addr_reg <= '0;
            len_reg <= '0;
            cs_reg <= '0;
            ce_reg <= '0;
            pa_reg <= '0;
            pl_reg <= '0;
            rem_a_reg <= '0;
            rem_l_reg <= '0;
            lowest_reg <= '0;
            need_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_addr];
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        addr_reg <= s_tdata[63:0];
                        len_reg <= s_tdata[127:64];
                        status_reg <= frta_pkg::ST_OK;
                        result_reg <= '0;
                        idx_reg <= '0;
                        found_reg <= 1'b0;
                        rem_pend_reg <= 1'b0;
                        put_ret_cut_reg <= 1'b0;
                        // a start at or past 4 GB overlaps nothing
                        cs_reg <= (s_tdata[63:32] != 32'd0) ? 33'h1_0000_0000 :
                            ({1'b0, s_tdata[31:0]} & ~{1'b0, PG_MASK[31:0]});
                        ce_reg <= ({1'b0, s_tdata[159:128]} + {1'b0, PG_MASK[31:0]})
                            & ~{1'b0, PG_MASK[31:0]};
                        case (s_tuser)
                            frta_pkg::OP_ADD:
                            begin
                                state_reg <= S_PUT;
                            end
                            frta_pkg::OP_CUT:
                            begin
                                kind_reg <= K_CUT;
                                state_reg <= S_RD;
                            end
                            frta_pkg::OP_ALLOC:
                            begin
                                if (s_tdata[127:64] == 64'd0)
                                begin
                                    status_reg <= frta_pkg::ST_ZERO;
                                    state_reg <= S_OUT;
                                end
                                else if (s_tdata[127:96] != 32'd0)
                                begin
                                    status_reg <= frta_pkg::ST_NO_FIT;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    kind_reg <= K_FIND;
                                    state_reg <= S_RD;
                                end
                            end
                            default:
                            begin
                                kind_reg <= K_PAGE;
                                status_reg <= frta_pkg::ST_NO_FIT;
                                idx_reg <= scan_lim - 6'd1;
                                state_reg <= (scan_lim == 6'd0) ? S_OUT : S_RD;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EV;
                end
                S_EV:
                begin
                    state_reg <= S_RD;
                    case (kind_reg)
                        K_FIND:
                        begin
                            if (idx_reg >= scan_lim)
                            begin
                                if (!found_reg)
                                begin
                                    status_reg <= frta_pkg::ST_NO_FIT;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    result_reg <= lowest_reg;
                                    bytes_reg <= bytes_reg + need_reg[31:0];
                                    cs_reg <= {1'b0, lowest_reg};
                                    ce_reg <= {1'b0, lowest_reg} + need_reg;
                                    kind_reg <= K_CUT;
                                    idx_reg <= '0;
                                end
                            end
                            else
                            begin
                                if ({1'b0, e_len} >= need_reg
                                    && (!found_reg || e_start < lowest_reg))
                                    lowest_reg <= e_start;
                                if ({1'b0, e_len} >= need_reg)
                                    found_reg <= 1'b1;
                                idx_reg <= idx_reg + 6'd1;
                            end
                        end
                        K_CUT:
                        begin
                            if (idx_reg >= scan_lim)
                                state_reg <= S_OUT;
                            else if (ev_ss < ev_se)
                            begin
                                put_ret_cut_reg <= 1'b1;
                                if (ev_ss > {1'b0, e_start})
                                begin
                                    addr_reg <= {32'd0, e_start};
                                    len_reg <= {31'd0, ev_ss - {1'b0, e_start}};
                                    rem_pend_reg <= (ev_se < ev_me);
                                    state_reg <= S_PUT;
                                end
                                else if (ev_se < ev_me)
                                begin
                                    addr_reg <= {31'd0, ev_se};
                                    len_reg <= {31'd0, ev_me - ev_se};
                                    rem_pend_reg <= 1'b0;
                                    state_reg <= S_PUT;
                                end
                                else
                                    idx_reg <= idx_reg + 6'd1;
                                rem_a_reg <= ev_se;
                                rem_l_reg <= ev_me - ev_se;
                            end
                            else
                                idx_reg <= idx_reg + 6'd1;
                        end
                        default:
                        begin
                            if (e_len >= PG_SIZE)
                            begin
                                bytes_reg <= bytes_reg + PG_SIZE;
                                result_reg <= e_start + e_len - PG_SIZE;
                                status_reg <= frta_pkg::ST_OK;
                                state_reg <= S_OUT;
                            end
                            else if (idx_reg == 6'd0)
                                state_reg <= S_OUT;
                            else
                                idx_reg <= idx_reg - 6'd1;
                        end
                    endcase
                end
                S_PUT:
                begin
                    if (na_drop)
                        state_reg <= S_CUT2;
                    else
                    begin
                        pa_reg <= na_a2[32:0];
                        pl_reg <= na_l2[32:0];
                        lowest_reg <= {26'd0, idx_reg};
                        idx_reg <= '0;
                        state_reg <= S_PRD;
                    end
                end
                S_PRD:
                begin
                    state_reg <= S_PEV;
                end
                S_PEV:
                begin
                    if (e_len == 32'd0)
                    begin
                        if (idx_reg >= 6'(slot_cnt_reg))
                            slot_cnt_reg <= idx_reg + 6'd1;
                        if (pa_reg + pl_reg > {1'b0, top_reg})
                            top_reg <= pa_reg[31:0] + pl_reg[31:0];
                        idx_reg <= lowest_reg[5:0];
                        state_reg <= S_CUT2;
                    end
                    else if (idx_reg == 6'(frta_pkg::MAP_ENTRIES - 1))
                    begin
                        status_reg <= status_reg | frta_pkg::ST_NO_SLOT;
                        idx_reg <= lowest_reg[5:0];
                        state_reg <= S_CUT2;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 6'd1;
                        state_reg <= S_PRD;
                    end
                end
                S_CUT2:
                begin
                    if (!put_ret_cut_reg)
                        state_reg <= S_OUT;
                    else if (rem_pend_reg)
                    begin
                        rem_pend_reg <= 1'b0;
                        addr_reg <= {31'd0, rem_a_reg};
                        len_reg <= {31'd0, rem_l_reg};
                        state_reg <= S_PUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 6'd1;
                        state_reg <= S_RD;
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (state_reg == S_IDLE && s_tvalid && s_tuser == frta_pkg::OP_ALLOC)
                need_reg <= 33'((s_tdata[127:64] + PG_MASK) & ~PG_MASK);
        end
    end
endmodule

/* tb/tb_free_range_table_allocator_top.sv */
// self-checking testbench for the free range table allocator
// predicts every response from its own copy of the range table; depends on frta_pkg
// and free_range_table_allocator_top
module tb_free_range_table_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [5:0]  entries_used;
        logic [31:0] allocated_bytes;
        logic [31:0] high_water;
        logic [1:0]  status;
        logic [31:0] result_addr;
    } alloc_resp_t;

    localparam logic [63:0] PAGE_SZ = 64'd1 << frta_pkg::PAGE_BITS;
    localparam logic [63:0] PAGE_MSK = PAGE_SZ - 64'd1;
    localparam logic [63:0] LIMIT64 = {32'd0, frta_pkg::ADDR_LIMIT};

    class range_table_scoreboard;
        logic [31:0] base_q[frta_pkg::MAP_ENTRIES];
        logic [31:0] size_q[frta_pkg::MAP_ENTRIES];
        logic [5:0]  used_slots;
        logic [31:0] top_end;
        logic [31:0] handed_out;
        alloc_resp_t expected_resp[$];
        int          errors;

        function new();
            for (int i = 0; i < frta_pkg::MAP_ENTRIES; i++)
            begin
                base_q[i] = '0;
                size_q[i] = '0;
            end
            used_slots = '0;
            top_end = '0;
            handed_out = '0;
            errors = 0;
        endfunction

        function logic [1:0] place_range(logic [63:0] a, logic [63:0] l);
            logic [63:0] hm;
            if (a > LIMIT64) return frta_pkg::ST_OK;
            if (l > LIMIT64 - a) l = LIMIT64 - a;
            if (l == 0) return frta_pkg::ST_OK;
            a = (a + PAGE_MSK) & ~PAGE_MSK;
            l = l & ~PAGE_MSK;
            if (a > LIMIT64) return frta_pkg::ST_OK;
            if (a + l > LIMIT64) l = (LIMIT64 - a) & ~PAGE_MSK;
            for (int m = 0; m < frta_pkg::MAP_ENTRIES; m++)
            begin
                if (size_q[m] != 0) continue;
                base_q[m] = a[31:0];
                size_q[m] = l[31:0];
                if (m >= used_slots) used_slots = 6'(m + 1);
                hm = a + l;
                if (hm > {32'd0, top_end}) top_end = hm[31:0];
                return frta_pkg::ST_OK;
            end
            return frta_pkg::ST_NO_SLOT;
        endfunction

        function logic [1:0] remove_range(logic [63:0] s, logic [63:0] e);
            logic [1:0]  st;
            logic [63:0] ma, me, ss, se;
            st = frta_pkg::ST_OK;
            s = s & ~PAGE_MSK;
            e = (e + PAGE_MSK) & ~PAGE_MSK;
            for (int m = 0; m < used_slots && m < frta_pkg::MAP_ENTRIES; m++)
            begin
                ma = {32'd0, base_q[m]};
                me = ma + {32'd0, size_q[m]};
                ss = s > ma ? s : ma;
                se = e < me ? e : me;
                if (ss >= se) continue;
                base_q[m] = '0;
                size_q[m] = '0;
                if (ss > ma) st |= place_range(ma, ss - ma);
                if (se < me) st |= place_range(se, me - se);
            end
            return st;
        endfunction

        function void note_request(logic [1:0] op, logic [63:0] addr, logic [63:0] len,
                                   logic [31:0] end_addr);
            alloc_resp_t r;
            logic [63:0] need;
            logic [31:0] lowest;
            bit          found;
            int          m;
            r = '0;
            if (op == frta_pkg::OP_ADD)
                r.status = place_range(addr, len);
            else if (op == frta_pkg::OP_CUT)
                r.status = remove_range(addr, {32'd0, end_addr});
            else if (op == frta_pkg::OP_ALLOC)
            begin
                if (len == 0)
                    r.status = frta_pkg::ST_ZERO;
                else if (len > {32'd0, frta_pkg::WORD_MAX})
                    r.status = frta_pkg::ST_NO_FIT;
                else
                begin
                    need = (len + PAGE_MSK) & ~PAGE_MSK;
                    found = 0;
                    lowest = '0;
                    for (m = 0; m < used_slots && m < frta_pkg::MAP_ENTRIES; m++)
                    begin
                        if ({32'd0, size_q[m]} < need) continue;
                        if (!found || base_q[m] < lowest) lowest = base_q[m];
                        found = 1;
                    end
                    if (!found)
                        r.status = frta_pkg::ST_NO_FIT;
                    else
                    begin
                        r.status = remove_range({32'd0, lowest}, {32'd0, lowest} + need);
                        handed_out = handed_out + need[31:0];
                        r.result_addr = lowest;
                    end
                end
            end
            else
            begin
                r.status = frta_pkg::ST_NO_FIT;
                m = used_slots < frta_pkg::MAP_ENTRIES ? used_slots : frta_pkg::MAP_ENTRIES;
                while (m > 0)
                begin
                    m--;
                    if ({32'd0, size_q[m]} < PAGE_SZ) continue;
                    size_q[m] = size_q[m] - PAGE_SZ[31:0];
                    handed_out = handed_out + PAGE_SZ[31:0];
                    r.result_addr = base_q[m] + size_q[m];
                    r.status = frta_pkg::ST_OK;
                    break;
                end
            end
            r.high_water = top_end;
            r.allocated_bytes = handed_out;
            r.entries_used = used_slots;
            expected_resp.push_back(r);
        endfunction

        function void check_response(alloc_resp_t act);
            alloc_resp_t exp;
            if (expected_resp.size() == 0)
            begin
                $display("%t: unexpected response %h", $realtime, act);
                errors++;
                return;
            end
            exp = expected_resp.pop_front();
            if (act.result_addr !== exp.result_addr)
                $display("%t: result_addr expected %h actual %h", $realtime,
                         exp.result_addr, act.result_addr);
            if (act.status !== exp.status)
                $display("%t: status expected %h actual %h", $realtime, exp.status, act.status);
            if (act.high_water !== exp.high_water)
                $display("%t: high_water expected %h actual %h", $realtime,
                         exp.high_water, act.high_water);
            if (act.allocated_bytes !== exp.allocated_bytes)
                $display("%t: allocated_bytes expected %h actual %h", $realtime,
                         exp.allocated_bytes, act.allocated_bytes);
            if (act.entries_used !== exp.entries_used)
                $display("%t: entries_used expected %h actual %h", $realtime,
                         exp.entries_used, act.entries_used);
            if (act !== exp) errors++;
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;   // addr, len, end_addr
    logic [1:0]   s_tuser = '0;   // op
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;        // result_addr, status, high_water, allocated_bytes, entries_used

    range_table_scoreboard sb = new();
    bit  src_idle_en = 1;
    bit  sink_idle_en = 1;
    bit  sink_hold = 0;
    bit  hold_start = 0;
    int  quiet_cycles = 0;

    free_range_table_allocator_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.note_request(s_tuser, s_tdata[63:0], s_tdata[127:64], s_tdata[159:128]);
        if (m_tvalid && m_tready)
            sb.check_response(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (sink_hold)
            m_tready <= 1'b0;
        else if (sink_idle_en)
            m_tready <= ($urandom_range(0, 99) >= 33);
        else
            m_tready <= 1'b1;
    end

    task automatic send_op(logic [1:0] op, logic [63:0] a, logic [63:0] l, logic [31:0] e);
        if (src_idle_en && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {e, l, a};
        s_tuser <= op;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [1:0]  op;
        logic [63:0] a, l;
        logic [31:0] e;
        int          k;
        op = 2'($urandom_range(0, 3));
        k = $urandom_range(0, 99);
        if (k < 8)
        begin
            a = {$urandom, $urandom};
            l = {$urandom, $urandom};
            e = $urandom;
        end
        else
        begin
            a = {44'd0, 8'($urandom_range(0, 255)), 12'd0};
            if ($urandom_range(0, 3) == 0) a[11:0] = 12'($urandom);
            l = {44'd0, 8'($urandom_range(0, 40)), 12'd0};
            if ($urandom_range(0, 3) == 0) l[11:0] = 12'($urandom);
            e = a[31:0] + {12'd0, 8'($urandom_range(0, 40)), 12'd0};
            if ($urandom_range(0, 3) == 0) e[11:0] = 12'($urandom);
        end
        if (op == frta_pkg::OP_ADD && $urandom_range(0, 99) < 40) op = frta_pkg::OP_CUT;
        send_op(op, a, l, e);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed corners
        send_op(frta_pkg::OP_PAGE, 64'd0, 64'd0, 32'd0);
        send_op(frta_pkg::OP_ALLOC, 64'd0, 64'd0, 32'd0);
        send_op(frta_pkg::OP_ALLOC, 64'd0, 64'd4096, 32'd0);
        send_op(frta_pkg::OP_ADD, 64'h0000_0000_0000_1001, 64'h0000_0000_0001_0000, 32'd0);
        send_op(frta_pkg::OP_ADD, 64'h0000_0000_0004_0000, 64'h0000_0000_0000_0800, 32'd0);
        send_op(frta_pkg::OP_ADD, 64'h0000_0000_FFFF_F001, 64'd4096, 32'd0);
        send_op(frta_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_op(frta_pkg::OP_ADD, 64'h0000_0000_FFFF_E800, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_op(frta_pkg::OP_ADD, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_op(frta_pkg::OP_ADD, 64'd0, 64'd0, 32'd0);
        send_op(frta_pkg::OP_CUT, 64'h0000_0000_8000_1800, 64'd0, 32'h8000_3001);
        send_op(frta_pkg::OP_CUT, 64'h0000_0000_9000_0000, 64'd0, 32'h8000_0000);
        send_op(frta_pkg::OP_CUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'hFFFF_FFFF);
        send_op(frta_pkg::OP_ALLOC, 64'd0, 64'h0000_0001_0000_0000, 32'd0);
        send_op(frta_pkg::OP_ALLOC, 64'd0, 64'h0000_0000_FFFF_FFFF, 32'd0);
        send_op(frta_pkg::OP_ALLOC, 64'd0, 64'd1, 32'd0);
        send_op(frta_pkg::OP_ALLOC, 64'd0, 64'h0000_0000_0000_3000, 32'd0);
        send_op(frta_pkg::OP_PAGE, 64'd0, 64'd0, 32'd0);
        send_op(frta_pkg::OP_PAGE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                32'hFFFF_FFFF);
        // fill the table to force no-slot
        for (int i = 0; i < 36; i++)
            send_op(frta_pkg::OP_ADD, 64'(i) << 20, 64'h2000, 32'd0);
        send_op(frta_pkg::OP_CUT, 64'h0000_0000_0000_0800, 64'd0, 32'h0FFF_F800);
        send_op(frta_pkg::OP_CUT, 64'd0, 64'd0, 32'hFFFF_FFFF);
        for (int i = 0; i < 1900; i++)
        begin
            if (i == 300)
            begin
                s_tvalid <= 1'b0;
                while (sb.expected_resp.size() != 0) @(posedge clk);
                @(negedge clk);
            end
            if (i == 600) hold_start = 1;
            if (i == 900)
            begin
                src_idle_en = 0;
                sink_idle_en = 0;
            end
            if (i == 1200)
            begin
                src_idle_en = 1;
                sink_idle_en = 1;
            end
            send_random();
        end
        s_tvalid <= 1'b0;
        while (sb.expected_resp.size() != 0) @(posedge clk);
        repeat (500) @(posedge clk);
        if (sb.errors == 0 && sb.expected_resp.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        wait (hold_start);
        sink_hold = 1;
        repeat (3000) @(posedge clk);
        sink_hold = 0;
    end
endmodule
